### hdl/psc_pkg.sv
// shared types and constants for the pinned slot cache
// no dependencies
`default_nettype none
package psc_pkg;

  localparam int CAPACITY = 16;
  localparam int PIN_BITS = 8;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int PK_W     = 2;
  localparam int CAP_W    = 5;

  typedef enum logic [2:0] {
    MD_PROBE    = 3'd0,
    MD_COMPLETE = 3'd1,
    MD_PIN      = 3'd2,
    MD_UNPIN    = 3'd3,
    MD_DIRTY    = 3'd4,
    MD_CLEAN    = 3'd5,
    MD_EVICT    = 3'd6,
    MD_QUERY    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    LS_HIT      = 3'd0,
    LS_INFLIGHT = 3'd1,
    LS_MISS     = 3'd2,
    LS_FULL     = 3'd3,
    LS_NONE     = 3'd4
  } lstat_t;

  typedef enum logic [1:0] {
    ST_INVALID  = 2'd0,
    ST_INFLIGHT = 2'd1,
    ST_VALID    = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    PK_CLOCK = 2'd0,
    PK_LRU   = 2'd1,
    PK_FIFO  = 2'd2
  } policy_t;

  localparam logic CFG_POLICY   = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRCH, S_FREE, S_VCLK, S_VLRU, S_VFIFO,
    S_VICT, S_CLAIM, S_CMD, S_RM, S_APP, S_EMIT
  } fsm_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_SRCH, OP_FREE, OP_CLK, OP_LRU, OP_FIFO,
    OP_VICT, OP_CLAIM, OP_CMD, OP_RM, OP_APP, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   clr_i;
  } dp_cmd_t;

  typedef struct packed {
    logic probe;
    logic idx_ok;
    logic pol_clock;
    logic pol_lru;
    logic match;
    logic match_valid;
    logic free_ok;
    logic scan_end;
    logic clk_vic;
    logic lru_vic;
    logic fifo_vic;
    logic list_end;
    logic list_empty;
    logic evict_list;
  } dp_stat_t;

endpackage
`default_nettype wire

### hdl/psc_dpath.sv
// datapath of the pinned slot cache: slot arrays, policy state, scan counters
// depends on psc_pkg
`default_nettype none
module psc_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [psc_pkg::CAP_W-1:0]    cfg_data,
  input  wire logic [2:0]                   mode,
  input  wire logic [psc_pkg::KEY_W-1:0]    lookup_key,
  input  wire logic [psc_pkg::SLOT_W-1:0]   slot_index,
  input  wire psc_pkg::dp_cmd_t             cmd,
  output psc_pkg::dp_stat_t                 stat,
  output logic                              done,
  output logic [2:0]                        lookup_status,
  output logic [psc_pkg::SLOT_W-1:0]        result_slot,
  output logic                              evicted_valid,
  output logic [psc_pkg::KEY_W-1:0]         evicted_key,
  output logic [1:0]                        line_state,
  output logic [psc_pkg::PIN_BITS-1:0]      line_pins,
  output logic                              line_dirty,
  output logic [psc_pkg::KEY_W-1:0]         line_key,
  output logic [psc_pkg::CNT_W-1:0]         resident_count
);

  localparam int N = psc_pkg::CAPACITY;
  localparam logic [psc_pkg::PIN_BITS-1:0] PIN_MAX = '1;

  logic [psc_pkg::PK_W-1:0]  policy_kind;
  logic [psc_pkg::CAP_W-1:0] capacity_in_use;

  logic [psc_pkg::KEY_W-1:0]    slot_keys [N];
  psc_pkg::slot_st_t            slot_states [N];
  logic [psc_pkg::PIN_BITS-1:0] slot_pins [N];
  logic                         slot_dirty [N];
  logic                         second_chance_bits [N];
  logic [psc_pkg::SLOT_W-1:0]   clock_hand;
  logic [psc_pkg::SLOT_W-1:0]   order_list [N];
  logic [psc_pkg::CNT_W-1:0]    order_length;
  logic [psc_pkg::CNT_W-1:0]    count;

  psc_pkg::mode_t               cur_mode;
  logic [psc_pkg::KEY_W-1:0]    cur_key;
  logic [psc_pkg::SLOT_W-1:0]   sel;
  logic [psc_pkg::CNT_W-1:0]    i;
  logic [psc_pkg::CNT_W-1:0]    j;
  psc_pkg::lstat_t              res_status;
  logic [psc_pkg::SLOT_W-1:0]   res_slot;
  logic                         res_evv;
  logic [psc_pkg::KEY_W-1:0]    res_evk;
  logic                         have_line;

  logic [psc_pkg::CNT_W-1:0]  cap;
  logic                       pol_clock, pol_lru;
  logic [psc_pkg::SLOT_W-1:0] ii, lru_s, fifo_f, rm_e, hand_next;
  logic [psc_pkg::CNT_W-1:0]  i_inc, j_new;
  logic                       rm_keep;
  logic                       clear;

  always_comb begin
    if (capacity_in_use == '0) begin
      cap = psc_pkg::CNT_W'(1);
    end else if (capacity_in_use > psc_pkg::CAP_W'(N)) begin
      cap = psc_pkg::CNT_W'(N);
    end else begin
      cap = psc_pkg::CNT_W'(capacity_in_use);
    end
  end

  assign pol_lru   = (policy_kind == psc_pkg::PK_LRU);
  assign pol_clock = !pol_lru && (policy_kind != psc_pkg::PK_FIFO);
  assign ii        = i[psc_pkg::SLOT_W-1:0];
  assign i_inc     = i + psc_pkg::CNT_W'(1);
  assign lru_s     = order_list[ii];
  assign fifo_f    = order_list[0];
  assign rm_e      = order_list[ii];
  assign rm_keep   = (i < order_length) && (rm_e != sel);
  assign j_new     = rm_keep ? j + psc_pkg::CNT_W'(1) : j;
  assign hand_next = (psc_pkg::CNT_W'(clock_hand) + psc_pkg::CNT_W'(1) >= cap)
                     ? '0 : clock_hand + psc_pkg::SLOT_W'(1);
  assign clear     = rst || cfg_write;

  always_comb begin
    stat.probe       = (cur_mode == psc_pkg::MD_PROBE);
    stat.idx_ok      = (psc_pkg::CNT_W'(sel) < cap);
    stat.pol_clock   = pol_clock;
    stat.pol_lru     = pol_lru;
    stat.match       = (slot_states[ii] != psc_pkg::ST_INVALID)
                       && (slot_keys[ii] == cur_key);
    stat.match_valid = (slot_states[ii] == psc_pkg::ST_VALID);
    stat.free_ok     = (slot_states[ii] == psc_pkg::ST_INVALID) && (slot_pins[ii] == '0);
    stat.scan_end    = (i_inc >= cap);
    stat.clk_vic     = (slot_pins[clock_hand] == '0) && !second_chance_bits[clock_hand];
    stat.lru_vic     = (i < order_length) && (psc_pkg::CNT_W'(lru_s) < cap)
                       && (slot_pins[lru_s] == '0);
    stat.fifo_vic    = (order_length != '0) && (psc_pkg::CNT_W'(fifo_f) < cap)
                       && (slot_pins[fifo_f] == '0);
    stat.list_end    = (i_inc >= order_length);
    stat.list_empty  = (order_length == '0);
    stat.evict_list  = (cur_mode == psc_pkg::MD_EVICT) && !pol_clock
                       && (slot_states[sel] != psc_pkg::ST_INVALID);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_kind     <= psc_pkg::PK_CLOCK;
      capacity_in_use <= psc_pkg::CAP_W'(N);
    end else if (cfg_write) begin
      if (cfg_index == psc_pkg::CFG_POLICY) begin
        policy_kind <= cfg_data[psc_pkg::PK_W-1:0];
      end else begin
        capacity_in_use <= cfg_data;
      end
    end
  end

  // per-command working registers
  always_ff @(posedge clk) begin
    if (cmd.op == psc_pkg::OP_LATCH) begin
      cur_mode   <= psc_pkg::mode_t'(mode);
      cur_key    <= lookup_key;
      sel        <= slot_index;
      res_slot   <= '0;
      res_evv    <= 1'b0;
      res_evk    <= '0;
      res_status <= (mode == psc_pkg::MD_PROBE) ? psc_pkg::LS_FULL : psc_pkg::LS_NONE;
      have_line  <= (mode != psc_pkg::MD_PROBE) && (psc_pkg::CNT_W'(slot_index) < cap);
    end
    case (cmd.op)
      psc_pkg::OP_SRCH: begin
        if (stat.match) begin
          sel        <= ii;
          res_slot   <= ii;
          have_line  <= 1'b1;
          res_status <= stat.match_valid ? psc_pkg::LS_HIT : psc_pkg::LS_INFLIGHT;
        end
      end
      psc_pkg::OP_FREE: if (stat.free_ok) sel <= ii;
      psc_pkg::OP_CLK:  if (stat.clk_vic) sel <= clock_hand;
      psc_pkg::OP_LRU:  if (stat.lru_vic) sel <= lru_s;
      psc_pkg::OP_FIFO: if (stat.fifo_vic) sel <= fifo_f;
      psc_pkg::OP_VICT: begin
        if (slot_states[sel] != psc_pkg::ST_INVALID) begin
          res_evv <= 1'b1;
          res_evk <= slot_keys[sel];
        end
      end
      psc_pkg::OP_CLAIM: begin
        res_status <= psc_pkg::LS_MISS;
        res_slot   <= sel;
        have_line  <= 1'b1;
      end
      psc_pkg::OP_CMD: begin
        if (cur_mode == psc_pkg::MD_EVICT && slot_states[sel] != psc_pkg::ST_INVALID) begin
          res_evv <= 1'b1;
          res_evk <= slot_keys[sel];
        end
      end
      default: ;
    endcase
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (cmd.clr_i) begin
      i <= '0;
      j <= '0;
    end else begin
      case (cmd.op)
        psc_pkg::OP_SRCH, psc_pkg::OP_FREE, psc_pkg::OP_CLK,
        psc_pkg::OP_LRU, psc_pkg::OP_FIFO: i <= i_inc;
        psc_pkg::OP_RM: begin
          i <= i_inc;
          j <= j_new;
        end
        default: ;
      endcase
    end
  end

  // slot arrays and policy state
  always_ff @(posedge clk) begin
    if (clear) begin
      for (int k = 0; k < N; k++) begin
        slot_keys[k]          <= '0;
        slot_states[k]        <= psc_pkg::ST_INVALID;
        slot_pins[k]          <= '0;
        slot_dirty[k]         <= 1'b0;
        second_chance_bits[k] <= 1'b0;
      end
      clock_hand   <= '0;
      order_length <= '0;
      count        <= '0;
    end else begin
      case (cmd.op)
        psc_pkg::OP_SRCH: begin
          if (stat.match && stat.match_valid && pol_clock) second_chance_bits[ii] <= 1'b1;
        end
        psc_pkg::OP_CLK: begin
          clock_hand <= hand_next;
          if (slot_pins[clock_hand] == '0 && second_chance_bits[clock_hand]) begin
            second_chance_bits[clock_hand] <= 1'b0;
          end
        end
        psc_pkg::OP_CLAIM: begin
          slot_keys[sel]          <= cur_key;
          slot_pins[sel]          <= '0;
          slot_dirty[sel]         <= 1'b0;
          slot_states[sel]        <= psc_pkg::ST_INFLIGHT;
          second_chance_bits[sel] <= 1'b0;
          if (slot_states[sel] == psc_pkg::ST_INVALID) count <= count + psc_pkg::CNT_W'(1);
        end
        psc_pkg::OP_CMD: begin
          case (cur_mode)
            psc_pkg::MD_COMPLETE: begin
              if (slot_states[sel] == psc_pkg::ST_INFLIGHT) slot_states[sel] <= psc_pkg::ST_VALID;
            end
            psc_pkg::MD_PIN:   if (slot_pins[sel] != PIN_MAX) slot_pins[sel] <= slot_pins[sel] + 1'b1;
            psc_pkg::MD_UNPIN: if (slot_pins[sel] != '0) slot_pins[sel] <= slot_pins[sel] - 1'b1;
            psc_pkg::MD_DIRTY: slot_dirty[sel] <= 1'b1;
            psc_pkg::MD_CLEAN: slot_dirty[sel] <= 1'b0;
            psc_pkg::MD_EVICT: begin
              if (slot_states[sel] != psc_pkg::ST_INVALID) begin
                count <= count - psc_pkg::CNT_W'(1);
                if (pol_clock) second_chance_bits[sel] <= 1'b0;
              end
              slot_states[sel] <= psc_pkg::ST_INVALID;
              slot_dirty[sel]  <= 1'b0;
            end
            default: ;
          endcase
        end
        psc_pkg::OP_RM:  if (stat.list_end && !stat.list_empty) order_length <= j_new;
        psc_pkg::OP_APP: begin
          if (order_length < psc_pkg::CNT_W'(N)) order_length <= order_length + psc_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // order list: compaction one entry per beat, rotate as a shift line
  always_ff @(posedge clk) begin
    case (cmd.op)
      psc_pkg::OP_RM: if (rm_keep) order_list[j[psc_pkg::SLOT_W-1:0]] <= rm_e;
      psc_pkg::OP_APP: begin
        if (order_length < psc_pkg::CNT_W'(N)) begin
          order_list[order_length[psc_pkg::SLOT_W-1:0]] <= sel;
        end
      end
      psc_pkg::OP_FIFO: begin
        if (!stat.fifo_vic) begin
          for (int k = 0; k < N; k++) begin
            if (psc_pkg::CNT_W'(k) + psc_pkg::CNT_W'(1) < order_length) begin
              order_list[k] <= order_list[(k + 1) % N];
            end else if (psc_pkg::CNT_W'(k) + psc_pkg::CNT_W'(1) == order_length) begin
              order_list[k] <= fifo_f;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == psc_pkg::OP_EMIT);
    end
    if (cmd.op == psc_pkg::OP_EMIT) begin
      lookup_status  <= res_status;
      result_slot    <= res_slot;
      evicted_valid  <= res_evv;
      evicted_key    <= res_evk;
      line_state     <= have_line ? slot_states[sel] : psc_pkg::ST_INVALID;
      line_pins      <= have_line ? slot_pins[sel] : '0;
      line_dirty     <= have_line && slot_dirty[sel];
      line_key       <= have_line ? slot_keys[sel] : '0;
      resident_count <= count;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= psc_pkg::CNT_W'(N))
    else $error("resident count beyond capacity");
  a_list_range: assert property (@(posedge clk) disable iff (rst)
    order_length <= psc_pkg::CNT_W'(N))
    else $error("order list overflow");
  a_evk_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evicted_valid) |-> (evicted_key == '0))
    else $error("evicted key without evicted flag");

endmodule
`default_nettype wire

### hdl/psc_ctrl.sv
// command sequencer of the pinned slot cache
// depends on psc_pkg
`default_nettype none
module psc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire psc_pkg::dp_stat_t stat,
  output logic                   busy,
  output psc_pkg::dp_cmd_t       cmd
);

  psc_pkg::fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      psc_pkg::S_IDLE: if (start) state_next = psc_pkg::S_DISP;
      psc_pkg::S_DISP: begin
        if (stat.probe) state_next = psc_pkg::S_SRCH;
        else if (stat.idx_ok) state_next = psc_pkg::S_CMD;
        else state_next = psc_pkg::S_EMIT;
      end
      psc_pkg::S_SRCH: begin
        if (stat.match) begin
          state_next = (stat.match_valid && stat.pol_lru) ? psc_pkg::S_RM : psc_pkg::S_EMIT;
        end else if (stat.scan_end) begin
          state_next = psc_pkg::S_FREE;
        end
      end
      psc_pkg::S_FREE: begin
        if (stat.free_ok) state_next = psc_pkg::S_CLAIM;
        else if (stat.scan_end) begin
          if (stat.pol_clock) state_next = psc_pkg::S_VCLK;
          else if (stat.pol_lru) state_next = psc_pkg::S_VLRU;
          else state_next = psc_pkg::S_VFIFO;
        end
      end
      psc_pkg::S_VCLK: begin
        if (stat.clk_vic) state_next = psc_pkg::S_VICT;
        else if (stat.scan_end) state_next = psc_pkg::S_EMIT;
      end
      psc_pkg::S_VLRU: begin
        if (stat.list_empty) state_next = psc_pkg::S_EMIT;
        else if (stat.lru_vic) state_next = psc_pkg::S_VICT;
        else if (stat.list_end) state_next = psc_pkg::S_EMIT;
      end
      psc_pkg::S_VFIFO: begin
        if (stat.list_empty) state_next = psc_pkg::S_EMIT;
        else if (stat.fifo_vic) state_next = psc_pkg::S_VICT;
        else if (stat.list_end) state_next = psc_pkg::S_EMIT;
      end
      psc_pkg::S_VICT:  state_next = psc_pkg::S_CLAIM;
      psc_pkg::S_CLAIM: state_next = stat.pol_clock ? psc_pkg::S_EMIT : psc_pkg::S_RM;
      psc_pkg::S_CMD:   state_next = stat.evict_list ? psc_pkg::S_RM : psc_pkg::S_EMIT;
      psc_pkg::S_RM: begin
        if (stat.list_end || stat.list_empty) begin
          state_next = stat.probe ? psc_pkg::S_APP : psc_pkg::S_EMIT;
        end
      end
      psc_pkg::S_APP:  state_next = psc_pkg::S_EMIT;
      psc_pkg::S_EMIT: state_next = psc_pkg::S_IDLE;
      default:         state_next = psc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = psc_pkg::OP_NONE;
    cmd.clr_i = 1'b0;
    busy      = (state != psc_pkg::S_IDLE);
    case (state)
      psc_pkg::S_IDLE: if (start) cmd.op = psc_pkg::OP_LATCH;
      psc_pkg::S_DISP: cmd.clr_i = 1'b1;
      psc_pkg::S_SRCH: begin
        cmd.op    = psc_pkg::OP_SRCH;
        cmd.clr_i = stat.match || stat.scan_end;
      end
      psc_pkg::S_FREE: begin
        cmd.op    = psc_pkg::OP_FREE;
        cmd.clr_i = stat.scan_end;
      end
      psc_pkg::S_VCLK:  cmd.op = psc_pkg::OP_CLK;
      psc_pkg::S_VLRU:  cmd.op = psc_pkg::OP_LRU;
      psc_pkg::S_VFIFO: cmd.op = psc_pkg::OP_FIFO;
      psc_pkg::S_VICT:  cmd.op = psc_pkg::OP_VICT;
      psc_pkg::S_CLAIM: begin
        cmd.op    = psc_pkg::OP_CLAIM;
        cmd.clr_i = 1'b1;
      end
      psc_pkg::S_CMD: begin
        cmd.op    = psc_pkg::OP_CMD;
        cmd.clr_i = 1'b1;
      end
      psc_pkg::S_RM:   cmd.op = psc_pkg::OP_RM;
      psc_pkg::S_APP:  cmd.op = psc_pkg::OP_APP;
      psc_pkg::S_EMIT: cmd.op = psc_pkg::OP_EMIT;
      default: ;
    endcase
  end

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == psc_pkg::S_EMIT) |=> (state == psc_pkg::S_IDLE))
    else $error("emit not followed by idle");
  a_latch_on_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == psc_pkg::S_DISP))
    else $error("accepted beat not dispatched");
  a_claim_path: assert property (@(posedge clk) disable iff (rst)
    (state == psc_pkg::S_VICT) |=> (state == psc_pkg::S_CLAIM))
    else $error("victim not claimed");

endmodule
`default_nettype wire

### hdl/pinned_slot_cache_with_replacement.sv
// top level of the pinned slot cache: sequencer plus datapath
// depends on psc_pkg, psc_ctrl, psc_dpath
`default_nettype none
// A command is taken when start is high and busy low; its one result beat
// appears on the result ports with done high for a single cycle, and the
// receiver cannot stall it. Non-probe commands pass through dispatch, the
// command step and the result step, skipping the command step when
// slot_index lies outside the capacity in use; an evict of a resident slot
// under LRU or FIFO adds an order-list compaction of one entry per cycle.
// A probe walks the slots one per cycle: a hit stops the walk, with the
// compaction and an append added for a valid hit under LRU; a miss adds a
// free-slot scan over the slots, a victim search over the slots (clock) or
// the order list (LRU, FIFO), and for the list policies the compaction plus
// an append. A configuration write resets all slots and policy state in the
// same cycle.
module pinned_slot_cache_with_replacement (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_index,
  input  wire logic [psc_pkg::CAP_W-1:0]  cfg_data,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [2:0]                 mode,
  input  wire logic [psc_pkg::KEY_W-1:0]  lookup_key,
  input  wire logic [psc_pkg::SLOT_W-1:0] slot_index,
  output logic                            done,
  output logic [2:0]                      lookup_status,
  output logic [psc_pkg::SLOT_W-1:0]      result_slot,
  output logic                            evicted_valid,
  output logic [psc_pkg::KEY_W-1:0]       evicted_key,
  output logic [1:0]                      line_state,
  output logic [psc_pkg::PIN_BITS-1:0]    line_pins,
  output logic                            line_dirty,
  output logic [psc_pkg::KEY_W-1:0]       line_key,
  output logic [psc_pkg::CNT_W-1:0]       resident_count
);

  psc_pkg::dp_cmd_t  cmd;
  psc_pkg::dp_stat_t stat;

  psc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  psc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mode           (mode),
    .lookup_key     (lookup_key),
    .slot_index     (slot_index),
    .cmd            (cmd),
    .stat           (stat),
    .done           (done),
    .lookup_status  (lookup_status),
    .result_slot    (result_slot),
    .evicted_valid  (evicted_valid),
    .evicted_key    (evicted_key),
    .line_state     (line_state),
    .line_pins      (line_pins),
    .line_dirty     (line_dirty),
    .line_key       (line_key),
    .resident_count (resident_count)
  );

endmodule
`default_nettype wire
